// ----- design/pbl_pkg.sv -----
package pbl_pkg;

    localparam int MAX_LABEL_BYTES_DEF = 32;
    localparam int OFFSET_BITS_DEF     = 16;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OFS_OUT_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_LEN_W   = 6;

    localparam int DASH_RUN       = 5;
    localparam int KIND_BEGIN_LEN = 5;
    localparam int KIND_END_LEN   = 3;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // "BEGIN" and "END", first character in the lowest byte
    localparam logic [KIND_BEGIN_LEN-1:0][7:0] KIND_BEGIN = 40'h4E_49_47_45_42;
    localparam logic [KIND_END_LEN-1:0][7:0]   KIND_END   = 24'h44_4E_45;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LABEL_LEN   = 3'd0,
        CFG_LABEL_0_7   = 3'd1,
        CFG_LABEL_8_15  = 3'd2,
        CFG_LABEL_16_23 = 3'd3,
        CFG_LABEL_24_31 = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_SEEK_BEGIN,
        PH_AFTER_BEGIN,
        PH_AFTER_CR,
        PH_SEEK_END,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND,
        ST_NO_BEGIN,
        ST_NO_END,
        ST_TOO_LONG
    } t_status;

    typedef struct packed {
        logic [OFS_OUT_W-1:0] body_length;
        logic [OFS_OUT_W-1:0] body_offset;
        t_status              status;
    } t_result;

endpackage

// ----- design/pbl_cfg.sv -----
module pbl_cfg #(
    parameter int MAX_LABEL_BYTES = pbl_pkg::MAX_LABEL_BYTES_DEF,
    parameter int LEN_W           = $clog2(MAX_LABEL_BYTES + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pbl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pbl_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    output logic [LEN_W-1:0]                      o_label_len,
    output logic [MAX_LABEL_BYTES-1:0][7:0]       o_label
);
    import pbl_pkg::*;

    logic [LEN_W-1:0]                r_label_len;
    logic [LEN_W-1:0]                n_label_len;
    logic [MAX_LABEL_BYTES-1:0][7:0] r_label;

    always_comb begin
        if (i_cfg_wdata[CFG_LEN_W-1:0] > CFG_LEN_W'(MAX_LABEL_BYTES)) begin
            n_label_len = LEN_W'(MAX_LABEL_BYTES);
        end else begin
            n_label_len = LEN_W'(i_cfg_wdata[CFG_LEN_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_len <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_LABEL_LEN) begin
            r_label_len <= n_label_len;
        end
    end

    for (genvar j = 0; j < MAX_LABEL_BYTES; j++) begin : g_byte
        localparam int SEL = int'(CFG_LABEL_0_7) + j / 8;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_label[j] <= '0;
            end else if (i_cfg_we && i_cfg_index == CFG_IDX_W'(SEL)) begin
                r_label[j] <= i_cfg_wdata[8*(j%8) +: 8];
            end
        end
    end

    assign o_label_len = r_label_len;
    assign o_label     = r_label;

endmodule

// ----- design/pbl_pattern.sv -----
module pbl_pattern #(
    parameter int MAX_LABEL_BYTES = pbl_pkg::MAX_LABEL_BYTES_DEF,
    parameter int LEN_W           = $clog2(MAX_LABEL_BYTES + 1),
    parameter int IDX_W           = $clog2(MAX_LABEL_BYTES + 16)
) (
    input  logic                            i_is_end,
    input  logic [IDX_W-1:0]                i_index,
    input  logic [LEN_W-1:0]                i_label_len,
    input  logic [MAX_LABEL_BYTES-1:0][7:0] i_label,
    output logic [7:0]                      o_byte
);
    import pbl_pkg::*;

    localparam int SUM_W = IDX_W + 1;

    logic [SUM_W-1:0] w_k;
    logic [SUM_W-1:0] w_klen;
    logic [SUM_W-1:0] w_label_end;
    logic [IDX_W-1:0] w_kind_idx;
    logic [IDX_W-1:0] w_lbl_idx;
    logic [7:0]       w_kind_byte;
    logic [7:0]       w_lbl_byte;

    // boundary line: dashes, kind word, space, label, dashes
    assign w_k         = SUM_W'(i_index);
    assign w_klen      = i_is_end ? SUM_W'(KIND_END_LEN) : SUM_W'(KIND_BEGIN_LEN);
    assign w_label_end = SUM_W'(DASH_RUN + 1) + w_klen + SUM_W'(i_label_len);
    assign w_kind_idx  = i_index - IDX_W'(DASH_RUN);
    assign w_lbl_idx   = IDX_W'(w_k - SUM_W'(DASH_RUN + 1) - w_klen);

    always_comb begin
        w_kind_byte = CH_DASH;
        if (i_is_end) begin
            for (int i = 0; i < KIND_END_LEN; i++) begin
                if (w_kind_idx == IDX_W'(i)) w_kind_byte = KIND_END[i];
            end
        end else begin
            for (int i = 0; i < KIND_BEGIN_LEN; i++) begin
                if (w_kind_idx == IDX_W'(i)) w_kind_byte = KIND_BEGIN[i];
            end
        end
    end

    always_comb begin
        w_lbl_byte = CH_DASH;
        for (int j = 0; j < MAX_LABEL_BYTES; j++) begin
            if (w_lbl_idx == IDX_W'(j)) w_lbl_byte = i_label[j];
        end
    end

    always_comb begin
        if (w_k < SUM_W'(DASH_RUN)) begin
            o_byte = CH_DASH;
        end else if (w_k < SUM_W'(DASH_RUN) + w_klen) begin
            o_byte = w_kind_byte;
        end else if (w_k == SUM_W'(DASH_RUN) + w_klen) begin
            o_byte = CH_SPACE;
        end else if (w_k < w_label_end) begin
            o_byte = w_lbl_byte;
        end else begin
            o_byte = CH_DASH;
        end
    end

endmodule

// ----- design/pbl_core.sv -----
module pbl_core #(
    parameter int MAX_LABEL_BYTES = pbl_pkg::MAX_LABEL_BYTES_DEF,
    parameter int OFFSET_BITS     = pbl_pkg::OFFSET_BITS_DEF,
    parameter int LEN_W           = $clog2(MAX_LABEL_BYTES + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [7:0]                      i_byte,
    input  logic                            i_fin,
    input  logic [LEN_W-1:0]                i_label_len,
    input  logic [MAX_LABEL_BYTES-1:0][7:0] i_label,
    output logic                            o_res_valid,
    output pbl_pkg::t_result                o_res
);
    import pbl_pkg::*;

    localparam int IDX_W = $clog2(MAX_LABEL_BYTES + 16);
    localparam int SUM_W = IDX_W + 1;
    localparam int POS_W = OFFSET_BITS + 1;

    t_phase           r_phase;
    t_phase           n_phase;
    t_phase           w_step_phase;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_bol;
    logic             n_bol;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_alive;
    logic             n_alive;
    logic [POS_W-1:0] r_body_start;
    logic [POS_W-1:0] n_body_start;
    logic [POS_W-1:0] r_end_start;
    logic [POS_W-1:0] n_end_start;

    logic             w_too_long;
    logic             w_active;
    logic             w_is_end;
    logic             w_matching;
    logic [IDX_W-1:0] w_cur_idx;
    logic             w_cur_alive;
    logic [7:0]       w_pat_byte;
    logic             w_hit;
    logic [SUM_W-1:0] w_plen;
    logic             w_last;
    logic             w_match_done;
    logic             w_end_done;
    logic [POS_W-1:0] w_body_len;

    assign w_too_long  = r_pos[OFFSET_BITS];
    assign w_active    = i_fire && r_phase != PH_DONE;
    assign w_is_end    = r_phase == PH_SEEK_END;
    assign w_matching  = r_phase == PH_SEEK_BEGIN || r_phase == PH_SEEK_END;
    assign w_cur_idx   = r_bol ? '0 : r_idx;
    assign w_cur_alive = r_bol ? (i_label_len != '0) : r_alive;

    pbl_pattern #(
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES),
        .LEN_W           (LEN_W),
        .IDX_W           (IDX_W)
    ) u_pattern (
        .i_is_end    (w_is_end),
        .i_index     (w_cur_idx),
        .i_label_len (i_label_len),
        .i_label     (i_label),
        .o_byte      (w_pat_byte)
    );

    assign w_hit  = i_byte == w_pat_byte;
    assign w_plen = SUM_W'(2 * DASH_RUN + 1)
                  + (w_is_end ? SUM_W'(KIND_END_LEN) : SUM_W'(KIND_BEGIN_LEN))
                  + SUM_W'(i_label_len);
    assign w_last = SUM_W'(w_cur_idx) + SUM_W'(1) == w_plen;
    assign w_match_done = w_matching && w_cur_alive && w_hit && w_last;
    assign w_end_done   = w_active && !w_too_long && w_is_end && w_match_done;
    assign w_body_len   = r_end_start - r_body_start;

    always_comb begin
        w_step_phase = r_phase;
        if (w_active) begin
            if (w_too_long) begin
                w_step_phase = PH_DONE;
            end else begin
                unique case (r_phase)
                    PH_SEEK_BEGIN: begin
                        if (w_match_done) w_step_phase = PH_AFTER_BEGIN;
                    end
                    PH_AFTER_BEGIN: begin
                        if (i_byte == CH_CR) begin
                            w_step_phase = PH_AFTER_CR;
                        end else if (i_byte == CH_LF) begin
                            w_step_phase = PH_SEEK_END;
                        end else begin
                            w_step_phase = PH_SEEK_BEGIN;
                        end
                    end
                    PH_AFTER_CR: w_step_phase = PH_SEEK_END;
                    PH_SEEK_END: begin
                        if (w_match_done) w_step_phase = PH_DONE;
                    end
                    default: w_step_phase = r_phase;
                endcase
            end
        end
        n_phase = (i_fire && i_fin) ? PH_SEEK_BEGIN : w_step_phase;
    end

    always_comb begin
        n_pos        = r_pos;
        n_bol        = r_bol;
        n_idx        = r_idx;
        n_alive      = r_alive;
        n_body_start = r_body_start;
        n_end_start  = r_end_start;
        if (w_active && !w_too_long) begin
            n_pos = r_pos + POS_W'(1);
            n_bol = i_byte == CH_LF;
            if (w_matching) begin
                n_idx   = w_cur_idx;
                n_alive = w_cur_alive;
                if (r_bol && w_is_end) n_end_start = r_pos;
                if (w_cur_alive) begin
                    if (!w_hit) begin
                        n_alive = 1'b0;
                    end else if (w_last) begin
                        n_alive = 1'b0;
                        n_idx   = '0;
                    end else begin
                        n_idx = w_cur_idx + IDX_W'(1);
                    end
                end
            end else if (r_phase == PH_AFTER_BEGIN) begin
                if (i_byte == CH_LF) begin
                    n_body_start = r_pos + POS_W'(1);
                end else if (i_byte != CH_CR) begin
                    n_alive = 1'b0;
                end
            end else begin
                n_body_start = (i_byte == CH_LF) ? r_pos + POS_W'(1) : r_pos;
            end
        end
        if (i_fire && i_fin) begin
            n_pos        = '0;
            n_bol        = 1'b1;
            n_idx        = '0;
            n_alive      = 1'b0;
            n_body_start = '0;
            n_end_start  = '0;
        end
    end

    always_comb begin
        o_res_valid = w_active && (w_too_long || w_end_done || i_fin);
        o_res       = '0;
        if (w_too_long) begin
            o_res.status = ST_TOO_LONG;
        end else if (w_end_done) begin
            o_res.status      = ST_FOUND;
            o_res.body_offset = OFS_OUT_W'(r_body_start);
            o_res.body_length = OFS_OUT_W'(w_body_len);
        end else if (w_step_phase == PH_SEEK_BEGIN) begin
            o_res.status = ST_NO_BEGIN;
        end else begin
            o_res.status = ST_NO_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEEK_BEGIN;
            r_pos        <= '0;
            r_bol        <= 1'b1;
            r_idx        <= '0;
            r_alive      <= 1'b0;
            r_body_start <= '0;
            r_end_start  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_bol        <= n_bol;
            r_idx        <= n_idx;
            r_alive      <= n_alive;
            r_body_start <= n_body_start;
            r_end_start  <= n_end_start;
        end
    end

endmodule

// ----- design/pem_boundary_locator.sv -----
// Channel   Direction  tdata (low bit up)                                  tlast
// s_axis    in         text_byte[7:0]                                      final_byte
// m_axis    out        status[1:0], body_offset[17:2], body_length[33:18]  -
// cfg       in         i_cfg_we / i_cfg_index / i_cfg_wdata, write only    -
//
// One byte per cycle while m_axis is not stalled; a byte waits in the input register and its
// result, if any, is registered into the output register when that byte is consumed.
// Byte-to-byte throughput is set by the combinational matcher/state update.
// Reset is synchronous and active low; label registers clear to zero.
// A stalled m_axis holds the pending result and backs up into s_axis.
module pem_boundary_locator #(
    parameter int MAX_LABEL_BYTES = pbl_pkg::MAX_LABEL_BYTES_DEF,
    parameter int OFFSET_BITS     = pbl_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pbl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // text_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pbl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // status, body_offset, body_length
    input  logic                              i_cfg_we,
    input  logic [pbl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pbl_pkg::*;

    localparam int LEN_W = $clog2(MAX_LABEL_BYTES + 1);

    logic                            r_in_valid;
    logic [7:0]                      r_in_byte;
    logic                            r_in_fin;
    logic                            r_out_valid;
    t_result                         r_out;
    logic                            w_fire;
    logic                            w_res_valid;
    t_result                         w_res;
    logic [LEN_W-1:0]                w_label_len;
    logic [MAX_LABEL_BYTES-1:0][7:0] w_label;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    pbl_cfg #(
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES),
        .LEN_W           (LEN_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_label_len (w_label_len),
        .o_label     (w_label)
    );

    pbl_core #(
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES),
        .OFFSET_BITS     (OFFSET_BITS),
        .LEN_W           (LEN_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_fin       (r_in_fin),
        .i_label_len (w_label_len),
        .i_label     (w_label),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_fin  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule
